// ===== hw/rtl/bpl_pkg.sv =====
// Shared types and codes for the bounded positional list unit.
// Used by bounded_positional_list_unit; no dependencies.
`default_nettype none

package bpl_pkg;

    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;
    localparam int CMD_W    = 3;

    // Command selectors
    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_AT    = 3'd5;
    localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd6;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    // Command beat
    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } cmd_t;

    // Result beat
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        count;
        logic signed [VALUE_W-1:0] item_value;
        logic                      last;
    } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bounded_positional_list_unit.sv =====
// Top level of the bounded positional list unit.
// Depends on bpl_pkg and bpl_ram.
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values, kept as a circular
// doubly linked chain of slots in three RAMs (values, forward links, backward
// links). A new element takes the lowest free slot. One command is handled at
// a time; the next is taken once the last beat of the current one has been
// placed in the output register. Walks follow forward links at one RAM read
// per cycle, which sets the cost of positional commands and dumps; a dump's
// reads also wait while the output register is stalled. Every command except
// a non-empty dump returns exactly one beat; a dump returns one beat per
// element, front to back, with last set on the final one. Count is reported
// in 5 bits.
module bounded_positional_list_unit
    import bpl_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_stall,
    input  wire cmd_t cmd,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_INS_NEW,
        S_INS_LINK,
        S_INS_FIX,
        S_DEL_LINK,
        S_DUMP,
        S_RESP
    } state_t;

    state_t                    state_reg;
    logic [SW-1:0]             head_reg;
    logic [SW-1:0]             tail_reg;
    logic [CW-1:0]             count_reg;
    logic [CAPACITY-1:0]       free_reg;
    logic [SW-1:0]             cur_reg;
    logic [SW-1:0]             prev_reg;
    logic [SW-1:0]             slot_reg;
    logic [SW-1:0]             pred_reg;
    logic [SW-1:0]             succ_reg;
    logic [CW-1:0]             steps_reg;
    logic                      rd_pend_reg;
    logic                      is_del_reg;
    logic                      front_reg;
    logic                      back_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic                      out_valid_reg;
    rsp_t                      out_reg;

    // RAM ports
    logic               val_wr_en, val_rd_en;
    logic [SW-1:0]      val_wr_addr, val_rd_addr;
    logic [VALUE_W-1:0] val_wr_data, val_rd_data;
    logic               fwd_wr_en, fwd_rd_en;
    logic [SW-1:0]      fwd_wr_addr, fwd_rd_addr, fwd_wr_data, fwd_rd_data;
    logic               bwd_wr_en, bwd_rd_en;
    logic [SW-1:0]      bwd_wr_addr, bwd_rd_addr, bwd_wr_data, bwd_rd_data;

    logic          accept;
    logic          out_free;
    logic          full;
    logic          empty;
    logic [SW-1:0] cur;
    logic [SW-1:0] free_slot;
    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;
    logic [PW-1:0] ins_pos;
    logic [PW-1:0] del_pos;
    logic          ins_ok;
    logic          del_ok;

    bpl_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_val_ram (
        .clk     (clk),
        .wr_en   (val_wr_en),
        .wr_addr (val_wr_addr),
        .wr_data (val_wr_data),
        .rd_en   (val_rd_en),
        .rd_addr (val_rd_addr),
        .rd_data (val_rd_data)
    );

    bpl_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_fwd_ram (
        .clk     (clk),
        .wr_en   (fwd_wr_en),
        .wr_addr (fwd_wr_addr),
        .wr_data (fwd_wr_data),
        .rd_en   (fwd_rd_en),
        .rd_addr (fwd_rd_addr),
        .rd_data (fwd_rd_data)
    );

    bpl_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_bwd_ram (
        .clk     (clk),
        .wr_en   (bwd_wr_en),
        .wr_addr (bwd_wr_addr),
        .wr_data (bwd_wr_data),
        .rd_en   (bwd_rd_en),
        .rd_addr (bwd_rd_addr),
        .rd_data (bwd_rd_data)
    );

    // Handshake
    assign cmd_stall = (state_reg != S_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Walk cursor: the link just read, or the registered start slot
    assign cur = rd_pend_reg ? fwd_rd_data : cur_reg;

    // Lowest free slot
    always_comb
    begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                free_slot = SW'(i);
            end
        end
    end

    // Effective positions and range checks
    assign full    = (count_reg >= CW'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign pos_ext = PW'(cmd.position);
    assign cnt_ext = PW'(count_reg);

    always_comb
    begin
        case (cmd.cmd)
            CMD_INS_FRONT: ins_pos = PW'(1);
            CMD_INS_BACK:  ins_pos = cnt_ext + PW'(1);
            default:       ins_pos = pos_ext;
        endcase
        case (cmd.cmd)
            CMD_DEL_FRONT: del_pos = PW'(1);
            CMD_DEL_BACK:  del_pos = cnt_ext;
            default:       del_pos = pos_ext;
        endcase
    end

    assign ins_ok = (ins_pos >= PW'(1)) && (ins_pos <= cnt_ext + PW'(1));
    assign del_ok = (del_pos >= PW'(1)) && (del_pos <= cnt_ext);

    // RAM access per state
    always_comb
    begin
        val_wr_en   = 1'b0;
        val_wr_addr = slot_reg;
        val_wr_data = value_reg;
        val_rd_en   = 1'b0;
        val_rd_addr = head_reg;
        fwd_wr_en   = 1'b0;
        fwd_wr_addr = slot_reg;
        fwd_wr_data = succ_reg;
        fwd_rd_en   = 1'b0;
        fwd_rd_addr = head_reg;
        bwd_wr_en   = 1'b0;
        bwd_wr_addr = slot_reg;
        bwd_wr_data = pred_reg;
        bwd_rd_en   = 1'b0;
        bwd_rd_addr = cur;
        case (state_reg)
            S_IDLE:
            begin
                // first dump read starts at the head
                if (accept && (cmd.cmd == CMD_DUMP) && !empty)
                begin
                    val_rd_en = 1'b1;
                    fwd_rd_en = 1'b1;
                end
            end
            S_WALK:
            begin
                fwd_rd_addr = cur;
                if (steps_reg != '0)
                begin
                    fwd_rd_en = 1'b1;
                end
                else if (is_del_reg)
                begin
                    // fetch both neighbors of the victim
                    fwd_rd_en = 1'b1;
                    bwd_rd_en = 1'b1;
                end
            end
            S_INS_NEW:
            begin
                val_wr_en   = 1'b1;
                fwd_wr_en   = 1'b1;
                fwd_wr_data = slot_reg;
                bwd_wr_en   = 1'b1;
                bwd_wr_data = slot_reg;
            end
            S_INS_LINK:
            begin
                val_wr_en = 1'b1;
                fwd_wr_en = 1'b1;
                bwd_wr_en = 1'b1;
            end
            S_INS_FIX:
            begin
                fwd_wr_en   = 1'b1;
                fwd_wr_addr = pred_reg;
                fwd_wr_data = slot_reg;
                bwd_wr_en   = 1'b1;
                bwd_wr_addr = succ_reg;
                bwd_wr_data = slot_reg;
            end
            S_DEL_LINK:
            begin
                // splice predecessor and successor together
                if (count_reg != CW'(1))
                begin
                    fwd_wr_en   = 1'b1;
                    fwd_wr_addr = bwd_rd_data;
                    fwd_wr_data = fwd_rd_data;
                    bwd_wr_en   = 1'b1;
                    bwd_wr_addr = fwd_rd_data;
                    bwd_wr_data = bwd_rd_data;
                end
            end
            S_DUMP:
            begin
                val_rd_addr = fwd_rd_data;
                fwd_rd_addr = fwd_rd_data;
                if (out_free && (steps_reg != CW'(1)))
                begin
                    val_rd_en = 1'b1;
                    fwd_rd_en = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer, list bookkeeping and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            free_reg      <= '1;
            cur_reg       <= '0;
            prev_reg      <= '0;
            slot_reg      <= '0;
            pred_reg      <= '0;
            succ_reg      <= '0;
            steps_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            is_del_reg    <= 1'b0;
            front_reg     <= 1'b0;
            back_reg      <= 1'b0;
            value_reg     <= '0;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && !rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        value_reg   <= cmd.value;
                        status_reg  <= ST_OK;
                        rd_pend_reg <= 1'b0;
                        case (cmd.cmd)
                            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT:
                            begin
                                is_del_reg <= 1'b0;
                                slot_reg   <= free_slot;
                                front_reg  <= (ins_pos == PW'(1));
                                back_reg   <= (ins_pos == cnt_ext + PW'(1));
                                if (full)
                                begin
                                    status_reg <= ST_FULL;
                                    state_reg  <= S_RESP;
                                end
                                else if (!ins_ok)
                                begin
                                    status_reg <= ST_BADPOS;
                                    state_reg  <= S_RESP;
                                end
                                else if (empty)
                                begin
                                    state_reg <= S_INS_NEW;
                                end
                                else if ((ins_pos == PW'(1)) ||
                                         (ins_pos == cnt_ext + PW'(1)))
                                begin
                                    // new slot goes between tail and head
                                    pred_reg  <= tail_reg;
                                    succ_reg  <= head_reg;
                                    state_reg <= S_INS_LINK;
                                end
                                else
                                begin
                                    cur_reg   <= head_reg;
                                    steps_reg <= CW'(ins_pos - PW'(1));
                                    state_reg <= S_WALK;
                                end
                            end
                            CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT:
                            begin
                                is_del_reg <= 1'b1;
                                if (empty)
                                begin
                                    status_reg <= ST_EMPTY;
                                    state_reg  <= S_RESP;
                                end
                                else if (!del_ok)
                                begin
                                    status_reg <= ST_BADPOS;
                                    state_reg  <= S_RESP;
                                end
                                else if (del_pos == cnt_ext)
                                begin
                                    cur_reg   <= tail_reg;
                                    steps_reg <= '0;
                                    state_reg <= S_WALK;
                                end
                                else
                                begin
                                    cur_reg   <= head_reg;
                                    steps_reg <= CW'(del_pos - PW'(1));
                                    state_reg <= S_WALK;
                                end
                            end
                            CMD_DUMP:
                            begin
                                if (empty)
                                begin
                                    status_reg <= ST_EMPTY;
                                    state_reg  <= S_RESP;
                                end
                                else
                                begin
                                    steps_reg <= count_reg;
                                    state_reg <= S_DUMP;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_RESP;
                            end
                        endcase
                    end
                end
                S_WALK:
                begin
                    cur_reg <= cur;
                    if (steps_reg != '0)
                    begin
                        prev_reg    <= cur;
                        rd_pend_reg <= 1'b1;
                        steps_reg   <= steps_reg - CW'(1);
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                        if (is_del_reg)
                        begin
                            state_reg <= S_DEL_LINK;
                        end
                        else
                        begin
                            pred_reg  <= prev_reg;
                            succ_reg  <= cur;
                            state_reg <= S_INS_LINK;
                        end
                    end
                end
                S_INS_NEW:
                begin
                    head_reg           <= slot_reg;
                    tail_reg           <= slot_reg;
                    count_reg          <= count_reg + CW'(1);
                    free_reg[slot_reg] <= 1'b0;
                    state_reg          <= S_RESP;
                end
                S_INS_LINK:
                begin
                    state_reg <= S_INS_FIX;
                end
                S_INS_FIX:
                begin
                    if (front_reg)
                    begin
                        head_reg <= slot_reg;
                    end
                    if (back_reg)
                    begin
                        tail_reg <= slot_reg;
                    end
                    count_reg          <= count_reg + CW'(1);
                    free_reg[slot_reg] <= 1'b0;
                    state_reg          <= S_RESP;
                end
                S_DEL_LINK:
                begin
                    // cur_reg holds the victim, RAM data its neighbors
                    if (count_reg == CW'(1))
                    begin
                        head_reg <= '0;
                        tail_reg <= '0;
                    end
                    else
                    begin
                        if (cur_reg == head_reg)
                        begin
                            head_reg <= fwd_rd_data;
                        end
                        if (cur_reg == tail_reg)
                        begin
                            tail_reg <= bwd_rd_data;
                        end
                    end
                    free_reg[cur_reg] <= 1'b1;
                    count_reg         <= count_reg - CW'(1);
                    state_reg         <= S_RESP;
                end
                S_DUMP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg      <= 1'b1;
                        out_reg.status     <= ST_OK;
                        out_reg.count      <= COUNT_W'(count_reg);
                        out_reg.item_value <= val_rd_data;
                        out_reg.last       <= (steps_reg == CW'(1));
                        if (steps_reg == CW'(1))
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            steps_reg <= steps_reg - CW'(1);
                        end
                    end
                end
                S_RESP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg      <= 1'b1;
                        out_reg.status     <= status_reg;
                        out_reg.count      <= COUNT_W'(count_reg);
                        out_reg.item_value <= '0;
                        out_reg.last       <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bpl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Read data holds while rd_en is low. No dependencies.
`default_nettype none

module bpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== tb/tb_bounded_positional_list_unit.sv =====
// Self-checking testbench for bounded_positional_list_unit: list edits, dumps, rejections.
// Depends on bpl_pkg and the unit RTL; keeps its own value-queue model of the list.
`timescale 1ns / 1ps

module tb_bounded_positional_list_unit;
    import bpl_pkg::*;

    localparam int LIST_CAP       = 16;
    localparam int QUIET_LIMIT    = 1000;
    localparam int LONG_HOLD      = 80;
    localparam int DRAIN_CYCLES   = 40;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // list contents front to back, and the beats still owed by the unit
    logic signed [VALUE_W-1:0] list_vals[$];
    rsp_t                      expected_rsp_q[$];

    int  errors;
    int  quiet_cycles;
    bit  tx_gaps_on;
    bit  rx_gaps_on;
    bit  rx_hold_req;

    bounded_positional_list_unit #(
        .CAPACITY (LIST_CAP)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Expected beats for one accepted command; updates the list model
    function automatic void predict_cmd(input cmd_t c);
        rsp_t r;
        int   n;
        int   p;
        n = list_vals.size();
        r = '0;
        r.status = ST_OK;
        r.last = 1'b1;
        case (c.cmd)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT:
            begin
                if (c.cmd == CMD_INS_FRONT)
                    p = 1;
                else if (c.cmd == CMD_INS_BACK)
                    p = n + 1;
                else
                    p = int'(c.position);
                // full is checked ahead of the position
                if (n >= LIST_CAP)
                    r.status = ST_FULL;
                else if (p < 1 || p > n + 1)
                    r.status = ST_BADPOS;
                else
                    list_vals.insert(p - 1, c.value);
            end
            CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT:
            begin
                if (c.cmd == CMD_DEL_FRONT)
                    p = 1;
                else if (c.cmd == CMD_DEL_BACK)
                    p = n;
                else
                    p = int'(c.position);
                // empty is checked ahead of the position
                if (n == 0)
                    r.status = ST_EMPTY;
                else if (p < 1 || p > n)
                    r.status = ST_BADPOS;
                else
                    list_vals.delete(p - 1);
            end
            CMD_DUMP:
            begin
                if (n == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        r.count = COUNT_W'(n);
                        r.item_value = list_vals[i];
                        r.last = (i == n - 1);
                        expected_rsp_q.push_back(r);
                    end
                    return;
                end
            end
            default: ;  // unused selector: no-op, one ok beat
        endcase
        r.count = COUNT_W'(list_vals.size());
        expected_rsp_q.push_back(r);
    endfunction

    function automatic cmd_t make_cmd(input logic [CMD_W-1:0] op,
                                      input logic signed [VALUE_W-1:0] val,
                                      input logic [POS_W-1:0] pos);
        cmd_t c;
        c.cmd = op;
        c.value = val;
        c.position = pos;
        return c;
    endfunction

    // Mostly random words, with the extremes mixed in
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Random command biased so the list wanders between empty and full
    function automatic cmd_t random_cmd();
        cmd_t c;
        int   n;
        int   sel;
        int   ins_pct;
        n = list_vals.size();
        sel = $urandom_range(0, 99);
        ins_pct = (n < 4) ? 60 : (n > 12) ? 30 : 45;
        c.value = pick_value();
        c.position = POS_W'($urandom_range(0, 31));
        if (sel < 2)
            c.cmd = CMD_UNUSED;
        else if (sel < 8)
            c.cmd = CMD_DUMP;
        else if (sel < 8 + ins_pct)
        begin
            c.cmd = CMD_INS_FRONT + CMD_W'($urandom_range(0, 2));
            if (c.cmd == CMD_INS_AT && $urandom_range(0, 99) < 85)
                c.position = POS_W'($urandom_range(1, n + 1));
        end
        else
        begin
            c.cmd = CMD_DEL_FRONT + CMD_W'($urandom_range(0, 2));
            if (c.cmd == CMD_DEL_AT && n > 0 && $urandom_range(0, 99) < 85)
                c.position = POS_W'($urandom_range(1, n));
        end
        return c;
    endfunction

    // Offer one command beat and wait for it to be taken
    task automatic issue_cmd(input cmd_t c);
        if (tx_gaps_on && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        predict_cmd(c);
    endtask

    // Edge cases on a short list, every command, and the empty and bad-position rejections
    task automatic test_empty_and_edges();
        issue_cmd(make_cmd(CMD_DUMP,      pick_value(), 5'd0));
        issue_cmd(make_cmd(CMD_DEL_FRONT, pick_value(), 5'd1));
        issue_cmd(make_cmd(CMD_DEL_BACK,  pick_value(), 5'd31));
        issue_cmd(make_cmd(CMD_DEL_AT,    pick_value(), 5'd1));
        issue_cmd(make_cmd(CMD_INS_AT,    VAL_MAX,      5'd0));
        issue_cmd(make_cmd(CMD_INS_AT,    VAL_MAX,      5'd2));
        issue_cmd(make_cmd(CMD_INS_AT,    VAL_MIN,      5'd1));
        issue_cmd(make_cmd(CMD_INS_FRONT, VAL_MAX,      5'd31));
        issue_cmd(make_cmd(CMD_INS_BACK,  '1,           5'd0));
        issue_cmd(make_cmd(CMD_INS_AT,    '0,           5'd2));
        issue_cmd(make_cmd(CMD_INS_AT,    32'h5555_5555, 5'd5));
        issue_cmd(make_cmd(CMD_INS_AT,    32'haaaa_aaaa, 5'd31));
        issue_cmd(make_cmd(CMD_DUMP,      '1,           5'd31));
        issue_cmd(make_cmd(CMD_DEL_AT,    '0,           5'd0));
        issue_cmd(make_cmd(CMD_DEL_AT,    '0,           5'd6));
        issue_cmd(make_cmd(CMD_DEL_AT,    '0,           5'd3));
        issue_cmd(make_cmd(CMD_UNUSED,    VAL_MIN,      5'd16));
        issue_cmd(make_cmd(CMD_DEL_BACK,  '0,           5'd0));
        issue_cmd(make_cmd(CMD_DEL_FRONT, '0,           5'd0));
        issue_cmd(make_cmd(CMD_DUMP,      '0,           5'd0));
        issue_cmd(make_cmd(CMD_DEL_AT,    '0,           5'd2));
        issue_cmd(make_cmd(CMD_DEL_AT,    '0,           5'd1));
        issue_cmd(make_cmd(CMD_INS_BACK,  32'haaaa_aaaa, 5'd0));
        issue_cmd(make_cmd(CMD_DEL_BACK,  '0,           5'd0));
    endtask

    // Fill to capacity, hit the full checks, dump, then drain to empty
    task automatic test_fill_to_capacity();
        while (list_vals.size() < LIST_CAP)
        begin
            if ($urandom_range(0, 1) == 0)
                issue_cmd(make_cmd(CMD_INS_BACK, pick_value(), 5'd0));
            else
                issue_cmd(make_cmd(CMD_INS_AT, pick_value(),
                                   POS_W'($urandom_range(1, list_vals.size() + 1))));
        end
        issue_cmd(make_cmd(CMD_INS_FRONT, pick_value(), 5'd1));
        issue_cmd(make_cmd(CMD_INS_AT,    pick_value(), 5'd17));
        issue_cmd(make_cmd(CMD_INS_AT,    pick_value(), 5'd0));
        issue_cmd(make_cmd(CMD_DEL_AT,    pick_value(), 5'd17));
        issue_cmd(make_cmd(CMD_DUMP,      pick_value(), 5'd0));
        issue_cmd(make_cmd(CMD_DEL_AT,    pick_value(), 5'd16));
        issue_cmd(make_cmd(CMD_INS_AT,    pick_value(), 5'd16));
        issue_cmd(make_cmd(CMD_UNUSED,    pick_value(), 5'd0));
        while (list_vals.size() > 0)
        begin
            case ($urandom_range(0, 2))
                0: issue_cmd(make_cmd(CMD_DEL_FRONT, pick_value(), 5'd0));
                1: issue_cmd(make_cmd(CMD_DEL_BACK, pick_value(), 5'd0));
                default: issue_cmd(make_cmd(CMD_DEL_AT, pick_value(),
                                            POS_W'($urandom_range(1, list_vals.size()))));
            endcase
        end
        issue_cmd(make_cmd(CMD_DEL_FRONT, pick_value(), 5'd0));
    endtask

    // Receiver holds off for a long stretch while commands keep coming
    task automatic test_output_backpressure();
        bit saved_gaps;
        saved_gaps = tx_gaps_on;
        tx_gaps_on = 1'b0;
        rx_hold_req = 1'b1;
        for (int i = 0; i < 6; i++)
            issue_cmd(make_cmd(CMD_INS_BACK, pick_value(), 5'd0));
        issue_cmd(make_cmd(CMD_DUMP, pick_value(), 5'd0));
        issue_cmd(make_cmd(CMD_DEL_AT, pick_value(), 5'd3));
        issue_cmd(make_cmd(CMD_DUMP, pick_value(), 5'd0));
        issue_cmd(make_cmd(CMD_INS_AT, pick_value(), 5'd2));
        issue_cmd(make_cmd(CMD_DEL_FRONT, pick_value(), 5'd0));
        issue_cmd(make_cmd(CMD_DUMP, pick_value(), 5'd0));
        tx_gaps_on = saved_gaps;
    endtask

    task automatic test_random_traffic(input int num_cmds);
        for (int i = 0; i < num_cmds; i++)
            issue_cmd(random_cmd());
    endtask

    // Closing stretch with both sides running flat out
    task automatic test_streaming(input int num_cmds);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        for (int i = 0; i < num_cmds; i++)
            issue_cmd(random_cmd());
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else if (rx_gaps_on && $urandom_range(0, 4) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // Compare each taken result beat with the oldest expectation
    always @(posedge clk)
    begin : check_rsp
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat status=%0d count=%0d value=%0d last=%0b",
                         $time, rsp.status, rsp.count, rsp.item_value, rsp.last);
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                if (rsp.status !== want.status || rsp.count !== want.count ||
                    rsp.item_value !== want.item_value || rsp.last !== want.last)
                begin
                    errors++;
                    $display({"%0t: mismatch exp status=%0d count=%0d value=%0d last=%0b",
                              " got status=%0d count=%0d value=%0d last=%0b"},
                             $time, want.status, want.count, want.item_value, want.last,
                             rsp.status, rsp.count, rsp.item_value, rsp.last);
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        quiet_cycles = 0;
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        rx_hold_req = 1'b0;
        rst_n <= 1'b0;
        cmd_valid <= 1'b0;
        cmd <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_edges();
        test_fill_to_capacity();
        test_output_backpressure();
        test_random_traffic(250);
        test_streaming(80);

        cmd_valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bpl_pkg.sv
hw/rtl/bpl_ram.sv
hw/rtl/bounded_positional_list_unit.sv
tb/tb_bounded_positional_list_unit.sv
